// ===== rtl/scfp_pkg.sv =====
// ----------------------------------------------------------------------------
// scfp_pkg: serial command frame parser definitions
// Types, codes and constants shared by the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package scfp_pkg;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h90;
  localparam logic [7:0] CLASS_HI_CODE   = 8'h07;
  localparam logic [7:0] CLASS_CONTROL   = 8'h05;
  localparam logic [7:0] CLASS_QUERY     = 8'h06;
  localparam logic [8:0] LENGTH_EXTRA    = 9'd7;
  localparam logic [7:0] CTYPE_MAX       = 8'd4;

  localparam logic [8:0] POS_CLASS_HI = 9'd2;
  localparam logic [8:0] POS_CLASS_LO = 9'd3;
  localparam logic [8:0] POS_LENGTH   = 9'd4;
  localparam logic [8:0] POS_CTYPE    = 9'd5;
  localparam logic [8:0] POS_ARG_A    = 9'd6;
  localparam logic [8:0] POS_ARG_B    = 9'd7;

  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_SYNC1 = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CONTROL = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_UNSUPP  = 2'd2
  } msg_kind_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_CODE0   = 3'd1,
    CMD_CODE1   = 3'd2,
    CMD_CODE2   = 3'd3,
    CMD_UNSUPP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_CLASS     = 2'd1,
    ERR_CTYPE     = 2'd2,
    ERR_TOO_SHORT = 2'd3
  } frame_err_t;

  // first member sits in the top bits: packed from tail_byte down to msg_kind
  typedef struct packed {
    logic [7:0] tail_byte;
    logic [7:0] checksum_byte;
    logic [8:0] frame_length;
    frame_err_t frame_error;
    cmd_t       mode_cmd;
    cmd_t       status_cmd;
    logic [7:0] arg_b;
    logic [7:0] arg_a;
    logic [7:0] control_type;
    msg_kind_t  msg_kind;
  } report_t;

  function automatic cmd_t decode_cmd(input logic [7:0] v);
    cmd_t c;
    case (v)
      8'd0:    c = CMD_CODE0;
      8'd1:    c = CMD_CODE1;
      8'd2:    c = CMD_CODE2;
      default: c = CMD_UNSUPP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Hunts sync bytes in a received byte stream, collects one command frame and
// emits one decoded report on the frame's tail byte.
// ----------------------------------------------------------------------------
// channel   | direction | tdata fields (lsb first)            | items
// in_       | slave     | rx_byte[7:0]                        | one byte
// out_      | master    | report, see out_tdata port          | one per frame
// cfg_      | write     | index 0 sync_first, 1 sync_second   | one register
//
// One byte per cycle while in_tready is high; the sync and frame state
// updates from each accepted byte, and the report is registered in the
// output register, or in the skid entry while the output is stalled.
// A two-entry output buffer (output register plus skid) holds one report
// behind a stalled output; in_tready drops only while the skid entry is full.
// Synchronous reset restores hunting and sync values 0xEB, 0x90, and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] msg_kind, [9:2] control_type, [17:10] arg_a, [25:18] arg_b,
  // [28:26] status_cmd, [31:29] mode_cmd, [33:32] frame_error,
  // [42:34] frame_length, [50:43] checksum_byte, [58:51] tail_byte, rest 0
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int unsigned REP_W = $bits(scfp_pkg::report_t);

  logic [7:0]        sync_first_r, sync_second_r;
  scfp_pkg::phase_t  phase_r, phase_nxt;
  logic [8:0]        pos_r, pos_nxt;
  logic [7:0]        class_hi_r, class_hi_nxt;
  logic [7:0]        class_lo_r, class_lo_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        ctype_r, ctype_nxt;
  logic [7:0]        arg_a_r, arg_a_nxt;
  logic [7:0]        arg_b_r, arg_b_nxt;
  logic [7:0]        chk_r, chk_nxt;

  logic              out_valid_r, skid_valid_r;
  scfp_pkg::report_t out_r, skid_r;

  logic              accept;
  logic              rep_valid;
  scfp_pkg::report_t rep;
  logic [8:0]        total;
  logic [7:0]        b;

  assign b         = in_tdata;
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign total     = {1'b0, len_nxt} + scfp_pkg::LENGTH_EXTRA;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    class_hi_nxt = class_hi_r;
    class_lo_nxt = class_lo_r;
    len_nxt      = len_r;
    ctype_nxt    = ctype_r;
    arg_a_nxt    = arg_a_r;
    arg_b_nxt    = arg_b_r;
    chk_nxt      = chk_r;
    rep_valid    = 1'b0;
    case (phase_r)
      scfp_pkg::PH_HUNT: begin
        if (b == sync_first_r) phase_nxt = scfp_pkg::PH_SYNC1;
      end
      scfp_pkg::PH_SYNC1: begin
        if (b == sync_second_r) begin
          phase_nxt = scfp_pkg::PH_FRAME;
          pos_nxt   = scfp_pkg::POS_CLASS_HI;
          ctype_nxt = 8'd0;
          arg_a_nxt = 8'd0;
          arg_b_nxt = 8'd0;
          chk_nxt   = 8'd0;
        end else if (b != sync_first_r) begin
          phase_nxt = scfp_pkg::PH_HUNT;
        end
      end
      scfp_pkg::PH_FRAME: begin
        case (pos_r)
          scfp_pkg::POS_CLASS_HI: class_hi_nxt = b;
          scfp_pkg::POS_CLASS_LO: class_lo_nxt = b;
          scfp_pkg::POS_LENGTH:   len_nxt      = b;
          scfp_pkg::POS_CTYPE:    ctype_nxt    = b;
          scfp_pkg::POS_ARG_A:    arg_a_nxt    = b;
          scfp_pkg::POS_ARG_B:    arg_b_nxt    = b;
          default: ;
        endcase
        if (pos_r < scfp_pkg::POS_CTYPE) begin
          pos_nxt = pos_r + 9'd1;
        end else begin
          if (pos_r == total - 9'd2) chk_nxt = b;
          if (pos_r != total - 9'd1) begin
            pos_nxt = pos_r + 9'd1;
          end else begin
            rep_valid = 1'b1;
            phase_nxt = scfp_pkg::PH_HUNT;
            pos_nxt   = 9'd0;
          end
        end
      end
      default: begin
        phase_nxt = scfp_pkg::PH_HUNT;
        pos_nxt   = 9'd0;
      end
    endcase
  end

  always_comb begin
    rep               = '0;
    rep.control_type  = ctype_nxt;
    rep.arg_a         = arg_a_nxt;
    rep.arg_b         = arg_b_nxt;
    rep.frame_length  = total;
    rep.checksum_byte = chk_nxt;
    rep.tail_byte     = b;
    rep.status_cmd    = scfp_pkg::CMD_NONE;
    rep.mode_cmd      = scfp_pkg::CMD_NONE;
    rep.frame_error   = scfp_pkg::ERR_NONE;
    if (class_hi_nxt == scfp_pkg::CLASS_HI_CODE
        && class_lo_nxt == scfp_pkg::CLASS_CONTROL) begin
      rep.msg_kind = scfp_pkg::KIND_CONTROL;
      if (total < 9'd8) begin
        rep.frame_error = scfp_pkg::ERR_TOO_SHORT;
      end else if (ctype_nxt > scfp_pkg::CTYPE_MAX) begin
        rep.frame_error = scfp_pkg::ERR_CTYPE;
      end else if (ctype_nxt == 8'd0) begin
        rep.status_cmd = scfp_pkg::decode_cmd(arg_a_nxt);
        rep.mode_cmd   = scfp_pkg::decode_cmd(arg_b_nxt);
      end
    end else if (class_hi_nxt == scfp_pkg::CLASS_HI_CODE
                 && class_lo_nxt == scfp_pkg::CLASS_QUERY) begin
      rep.msg_kind = scfp_pkg::KIND_QUERY;
    end else begin
      rep.msg_kind    = scfp_pkg::KIND_UNSUPP;
      rep.frame_error = scfp_pkg::ERR_CLASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= scfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= scfp_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr_en) begin
      case (scfp_pkg::cfg_idx_t'(cfg_addr))
        scfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        scfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scfp_pkg::PH_HUNT;
      pos_r   <= 9'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_hi_r <= 8'd0;
      class_lo_r <= 8'd0;
      len_r      <= 8'd0;
      ctype_r    <= 8'd0;
      arg_a_r    <= 8'd0;
      arg_b_r    <= 8'd0;
      chk_r      <= 8'd0;
    end else if (accept) begin
      class_hi_r <= class_hi_nxt;
      class_lo_r <= class_lo_nxt;
      len_r      <= len_nxt;
      ctype_r    <= ctype_nxt;
      arg_a_r    <= arg_a_nxt;
      arg_b_r    <= arg_b_nxt;
      chk_r      <= chk_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (accept && rep_valid) skid_valid_r <= 1'b1;
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= accept && rep_valid;
    end else begin
      out_valid_r  <= accept && rep_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (accept && rep_valid) skid_r <= rep;
    end else if (skid_valid_r) begin
      out_r <= skid_r;
      if (accept && rep_valid) skid_r <= rep;
    end else if (accept && rep_valid) begin
      out_r <= rep;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(scfp_pkg::OUT_TDATA_W - REP_W){1'b0}}, out_r};

endmodule

`default_nettype wire

// ===== tb/scfp_report_checker.sv =====
// ----------------------------------------------------------------------------
// scfp_report_checker: frame report predictor and comparator
// Watches the byte, report and register ports of the frame parser. It tracks
// sync hunting and frame collection for every accepted byte, queues the
// report that each tail byte should produce, and compares each accepted
// report field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module scfp_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] msg_kind, [9:2] control_type, [17:10] arg_a, [25:18] arg_b,
  // [28:26] status_cmd, [31:29] mode_cmd, [33:32] frame_error,
  // [42:34] frame_length, [50:43] checksum_byte, [58:51] tail_byte, rest 0
  input  logic [63:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  output int unsigned fail_count,
  output int unsigned pending_reports
);

  import scfp_pkg::*;

  localparam int REPORT_W = $bits(report_t);

  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    IN_FRAME
  } hunt_t;

  hunt_t      hunt;
  logic [8:0] pos;
  logic [7:0] sync_first_v;
  logic [7:0] sync_second_v;
  logic [7:0] cls_hi;
  logic [7:0] cls_lo;
  logic [7:0] len_byte;
  logic [7:0] ctype_byte;
  logic [7:0] arg_a_byte;
  logic [7:0] arg_b_byte;
  logic [7:0] cs_byte;

  report_t    expected_reports[$];
  report_t    want;
  report_t    got;

  initial begin
    fail_count      = 0;
    pending_reports = 0;
  end

  function automatic cmd_t cmd_of_arg(input logic [7:0] v);
    return (v <= 8'd2) ? cmd_t'(v[2:0] + 3'd1) : CMD_UNSUPP;
  endfunction

  task automatic match_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [8:0] total;
    report_t    r;
    case (hunt)
      SEEK_FIRST: begin
        if (b == sync_first_v) hunt = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        if (b == sync_second_v) begin
          hunt       = IN_FRAME;
          pos        = POS_CLASS_HI;
          ctype_byte = '0;
          arg_a_byte = '0;
          arg_b_byte = '0;
          cs_byte    = '0;
        end else if (b != sync_first_v) begin
          hunt = SEEK_FIRST;
        end
      end
      default: begin
        case (pos)
          POS_CLASS_HI: cls_hi     = b;
          POS_CLASS_LO: cls_lo     = b;
          POS_LENGTH:   len_byte   = b;
          POS_CTYPE:    ctype_byte = b;
          POS_ARG_A:    arg_a_byte = b;
          POS_ARG_B:    arg_b_byte = b;
          default: ;
        endcase
        if (pos < POS_CTYPE) begin
          pos = pos + 9'd1;
        end else begin
          total = {1'b0, len_byte} + LENGTH_EXTRA;
          if (pos == total - 9'd2) cs_byte = b;
          if (pos != total - 9'd1) begin
            pos = pos + 9'd1;
          end else begin
            r               = '0;
            r.control_type  = ctype_byte;
            r.arg_a         = arg_a_byte;
            r.arg_b         = arg_b_byte;
            r.status_cmd    = CMD_NONE;
            r.mode_cmd      = CMD_NONE;
            r.frame_error   = ERR_NONE;
            r.frame_length  = total;
            r.checksum_byte = cs_byte;
            r.tail_byte     = b;
            if (cls_hi == CLASS_HI_CODE && cls_lo == CLASS_CONTROL) begin
              r.msg_kind = KIND_CONTROL;
              if (total <= LENGTH_EXTRA) begin
                r.frame_error = ERR_TOO_SHORT;
              end else if (ctype_byte > CTYPE_MAX) begin
                r.frame_error = ERR_CTYPE;
              end else if (ctype_byte == 8'd0) begin
                r.status_cmd = cmd_of_arg(arg_a_byte);
                r.mode_cmd   = cmd_of_arg(arg_b_byte);
              end
            end else if (cls_hi == CLASS_HI_CODE && cls_lo == CLASS_QUERY) begin
              r.msg_kind = KIND_QUERY;
            end else begin
              r.msg_kind    = KIND_UNSUPP;
              r.frame_error = ERR_CLASS;
            end
            expected_reports.push_back(r);
            hunt = SEEK_FIRST;
            pos  = '0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hunt          = SEEK_FIRST;
      pos           = '0;
      sync_first_v  = SYNC_FIRST_RST;
      sync_second_v = SYNC_SECOND_RST;
      cls_hi        = '0;
      cls_lo        = '0;
      len_byte      = '0;
      ctype_byte    = '0;
      arg_a_byte    = '0;
      arg_b_byte    = '0;
      cs_byte       = '0;
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = report_t'(out_tdata[REPORT_W-1:0]);
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          match_field("msg_kind", want.msg_kind, got.msg_kind);
          match_field("control_type", want.control_type, got.control_type);
          match_field("arg_a", want.arg_a, got.arg_a);
          match_field("arg_b", want.arg_b, got.arg_b);
          match_field("status_cmd", want.status_cmd, got.status_cmd);
          match_field("mode_cmd", want.mode_cmd, got.mode_cmd);
          match_field("frame_error", want.frame_error, got.frame_error);
          match_field("frame_length", want.frame_length, got.frame_length);
          match_field("checksum_byte", want.checksum_byte, got.checksum_byte);
          match_field("tail_byte", want.tail_byte, got.tail_byte);
          match_field("tdata padding", '0, out_tdata[63:REPORT_W]);
        end
      end
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata);
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_SYNC_FIRST) sync_first_v = cfg_wdata;
        else sync_second_v = cfg_wdata;
      end
    end
    pending_reports = expected_reports.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: serial command frame parser testbench
// Feeds sync sequences, command frames, noise and broken sequences under
// several sync settings with random gaps on both channels, including one long
// output hold, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  import scfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_wr_en;
  cfg_idx_t    cfg_addr;
  logic [7:0]  cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_reports;
  int unsigned cycle_count = 0;
  int unsigned frame_bytes = 0;
  int unsigned frames_sent = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  logic [7:0]  cur_sync_first = SYNC_FIRST_RST;
  logic [7:0]  cur_sync_second = SYNC_SECOND_RST;

  serial_command_frame_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  scfp_report_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_arg();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame(input logic [7:0] ch, input logic [7:0] cl,
                            input logic [7:0] len, input logic [7:0] ctype,
                            input logic [7:0] arg_a, input logic [7:0] arg_b);
    logic [8:0] total;
    logic [7:0] v;
    total = {1'b0, len} + LENGTH_EXTRA;
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(ch);
    send_byte(cl);
    send_byte(len);
    for (int p = POS_CTYPE; p < total; p++) begin
      v = 8'($urandom_range(0, 255));
      if (p == POS_CTYPE) v = ctype;
      else if (p == POS_ARG_A) v = arg_a;
      else if (p == POS_ARG_B) v = arg_b;
      send_byte(v);
    end
    frame_bytes += total;
    frames_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_SYNC_FIRST) cur_sync_first = v;
    else cur_sync_second = v;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_traffic(input int unsigned n_bytes, input int unsigned n_frames);
    int unsigned b0;
    int unsigned f0;
    int unsigned sel;
    int unsigned r;
    logic [7:0]  ch;
    logic [7:0]  cl;
    logic [7:0]  len;
    logic [7:0]  ctype;
    b0 = frame_bytes;
    f0 = frames_sent;
    while (frame_bytes - b0 < n_bytes || frames_sent - f0 < n_frames) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          ch = CLASS_HI_CODE;
          cl = CLASS_CONTROL;
        end else if (r < 75) begin
          ch = CLASS_HI_CODE;
          cl = CLASS_QUERY;
        end else if (r < 88) begin
          ch = CLASS_HI_CODE;
          cl = 8'($urandom_range(0, 255));
        end else begin
          ch = 8'($urandom_range(0, 255));
          cl = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 75) len = 8'($urandom_range(0, 6));
        else if (r < 95) len = 8'($urandom_range(7, 40));
        else if (r < 99) len = 8'($urandom_range(41, 254));
        else len = 8'hFF;
        r = $urandom_range(0, 99);
        if (r < 55) ctype = 8'd0;
        else if (r < 75) ctype = 8'($urandom_range(1, 4));
        else if (r < 85) ctype = CTYPE_MAX + 8'd1;
        else ctype = 8'($urandom_range(0, 255));
        send_frame(ch, cl, len, ctype, pick_arg(), pick_arg());
      end else if (sel < 86) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 9) == 0) send_byte(cur_sync_first);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            send_byte(cur_sync_first);
            send_byte(8'($urandom_range(0, 255)));
          end
          1: begin
            repeat ($urandom_range(1, 3)) send_byte(cur_sync_first);
            send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'($urandom_range(0, 4)),
                       8'd0, pick_arg(), pick_arg());
          end
          default: begin
            send_byte(cur_sync_first);
            send_byte(cur_sync_second);
            send_byte(CLASS_HI_CODE);
          end
        endcase
      end
    end
  endtask

  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req && !stall_done) begin
        gap        = LONG_HOLD;
        stall_done = 1'b1;
      end else begin
        gap = pick_gap(rx_calm);
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_SYNC_FIRST;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd1, 8'd0, 8'd0, 8'd0);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd2, 8'd0, 8'd1, 8'd1);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd1, 8'd0, 8'd2, 8'd2);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd1, 8'd0, 8'd3, 8'hFF);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd1, CTYPE_MAX, 8'd0, 8'd0);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd1, CTYPE_MAX + 8'd1, 8'd0, 8'd0);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd3, 8'hFF, 8'hFF, 8'hFF);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'd0, 8'd0, 8'd1, 8'd2);
    send_frame(CLASS_HI_CODE, CLASS_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
    send_frame(CLASS_HI_CODE, CLASS_QUERY, 8'd4, 8'd0, 8'd1, 8'd2);
    send_frame(CLASS_HI_CODE, CLASS_HI_CODE, 8'd2, 8'd0, 8'd0, 8'd0);
    send_frame(8'h00, CLASS_CONTROL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync_first);
    send_byte(cur_sync_first);
    send_frame(8'hFF, 8'hFF, 8'd1, 8'd0, 8'd0, 8'd0);
    send_frame(CLASS_HI_CODE, CLASS_CONTROL, 8'hFF, 8'd0, 8'd0, 8'd1);
    settle();

    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    stall_req = 1'b1;
    random_traffic(40, 4);
    settle();

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    random_traffic(20, 2);
    settle();

    write_reg(CFG_SYNC_FIRST, 8'($urandom_range(0, 255)));
    write_reg(CFG_SYNC_SECOND, 8'($urandom_range(0, 255)));
    random_traffic(20, 2);
    settle();

    write_reg(CFG_SYNC_FIRST, 8'h5A);
    write_reg(CFG_SYNC_SECOND, 8'h5A);
    random_traffic(20, 2);
    settle();

    write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
    write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
    random_traffic(20, 2);
    settle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
